// ----- design/ttrim_pkg.sv -----
// ttrim_pkg: shared types and constants for the text trim stream block
// used by ttrim_ctrl, ttrim_dp and text_trim_stream; no dependencies
`timescale 1ns / 1ps

package ttrim_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_SET_LOW      = 3'd0;
    localparam logic [2:0] REG_SET_MID_LOW  = 3'd1;
    localparam logic [2:0] REG_SET_MID_HIGH = 3'd2;
    localparam logic [2:0] REG_SET_HIGH     = 3'd3;
    localparam logic [2:0] REG_USE_WS       = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int BYTE_W      = 8;

    // byte codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_LAST,
        ST_TERM
    } state_t;

    // source of the next result item
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_HELD,
        SRC_PENDING,
        SRC_TERM
    } out_src_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     in_ready;
        logic     capture;
        logic     push;
        logic     set_ovf;
        logic     set_body;
        logic     ptr_clear;
        logic     ptr_inc;
        logic     clear_count;
        logic     term_clear;
        logic     load_out;
        out_src_t src;
    } ttrim_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_nul;
        logic is_trim;
        logic in_body;
        logic cnt_zero;
        logic cnt_full;
        logic flush_last;
        logic out_free;
    } ttrim_stat_t;

endpackage

// ----- design/ttrim_dp.sv -----
// ttrim_dp: datapath of the text trim stream block
// holds config registers, trim classifier, pending buffer memory and output register
// depends on ttrim_pkg
`timescale 1ns / 1ps

module ttrim_dp #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [ttrim_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ttrim_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [ttrim_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                 m_tready,
    input  ttrim_pkg::ttrim_cmd_t                cmd,
    output ttrim_pkg::ttrim_stat_t               stat,
    output logic                                 m_tvalid,
    output logic [ttrim_pkg::BYTE_W-1:0]         m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tuser
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    // configuration registers
    logic [63:0] set_low_reg;
    logic [63:0] set_mid_low_reg;
    logic [63:0] set_mid_high_reg;
    logic [63:0] set_high_reg;
    logic        use_ws_reg;

    // string state
    logic          in_body_reg;
    logic          ovf_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;

    // pending buffer and held byte
    logic [ttrim_pkg::BYTE_W-1:0] mem [PENDING_DEPTH];
    logic [ttrim_pkg::BYTE_W-1:0] rd_data_reg;
    logic [ttrim_pkg::BYTE_W-1:0] held_reg;

    // output register
    logic                         out_valid_reg;
    logic [ttrim_pkg::BYTE_W-1:0] out_byte_reg;
    logic                         out_last_reg;
    logic                         out_ovf_reg;
    logic [ttrim_pkg::BYTE_W-1:0] out_byte_next;
    logic                         out_last_next;
    logic                         out_ovf_next;

    logic [63:0] set_word;
    logic        trim_ws;
    logic        out_free;

    // config write decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_low_reg      <= '0;
            set_mid_low_reg  <= '0;
            set_mid_high_reg <= '0;
            set_high_reg     <= '0;
            use_ws_reg       <= 1'b1;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                ttrim_pkg::REG_SET_LOW:      set_low_reg      <= cfg_wdata;
                ttrim_pkg::REG_SET_MID_LOW:  set_mid_low_reg  <= cfg_wdata;
                ttrim_pkg::REG_SET_MID_HIGH: set_mid_high_reg <= cfg_wdata;
                ttrim_pkg::REG_SET_HIGH:     set_high_reg     <= cfg_wdata;
                ttrim_pkg::REG_USE_WS:       use_ws_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // trim set classifier
    always_comb
    begin
        case (in_byte[7:6])
            2'd0:    set_word = set_low_reg;
            2'd1:    set_word = set_mid_low_reg;
            2'd2:    set_word = set_mid_high_reg;
            default: set_word = set_high_reg;
        endcase
        trim_ws = (in_byte == ttrim_pkg::CHAR_SPACE) ||
                  ((in_byte >= ttrim_pkg::CHAR_TAB) && (in_byte <= ttrim_pkg::CHAR_CR));
    end

    assign out_free = !out_valid_reg || m_tready;

    // status to controller
    always_comb
    begin
        stat.is_nul     = (in_byte == ttrim_pkg::CHAR_NUL);
        stat.is_trim    = use_ws_reg ? trim_ws : set_word[in_byte[5:0]];
        stat.in_body    = in_body_reg;
        stat.cnt_zero   = (count_reg == '0);
        stat.cnt_full   = (count_reg == CW'(PENDING_DEPTH));
        stat.flush_last = (CW'(ptr_reg) == count_reg - CW'(1));
        stat.out_free   = out_free;
    end

    // pending count and flush pointer next values
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count || cmd.term_clear)
            count_next = '0;
        else if (cmd.push)
            count_next = count_reg + CW'(1);

        ptr_next = ptr_reg;
        if (cmd.ptr_clear)
            ptr_next = '0;
        else if (cmd.ptr_inc)
            ptr_next = AW'(ptr_reg + AW'(1));
    end

    // string state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            count_reg   <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (cmd.term_clear)
            begin
                in_body_reg <= 1'b0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.set_body)
                    in_body_reg <= 1'b1;
                if (cmd.set_ovf)
                    ovf_reg <= 1'b1;
            end
        end
    end

    // pending buffer memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[count_reg[AW-1:0]] <= in_byte;
        rd_data_reg <= mem[ptr_next];
    end

    // held non-trim byte waiting for its flush
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            held_reg <= in_byte;
    end

    // result item select
    always_comb
    begin
        out_byte_next = in_byte;
        out_last_next = 1'b1;
        out_ovf_next  = 1'b0;
        case (cmd.src)
            ttrim_pkg::SRC_INPUT:
            begin
                out_byte_next = in_byte;
            end
            ttrim_pkg::SRC_HELD:
            begin
                out_byte_next = held_reg;
            end
            ttrim_pkg::SRC_PENDING:
            begin
                out_byte_next = rd_data_reg;
                out_last_next = 1'b0;
            end
            default:
            begin
                out_byte_next = ttrim_pkg::CHAR_NUL;
                out_ovf_next  = ovf_reg;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= out_last_next;
            out_ovf_reg  <= out_ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    // pending count stays within the buffer
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PENDING_DEPTH))
        else $error("pending count beyond buffer depth");

    // a result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over an untaken item");

    // terminator leaves the string state cleared
    a_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.term_clear |=> (count_reg == '0) && !in_body_reg && !ovf_reg)
        else $error("string state not cleared after terminator");

endmodule

// ----- design/ttrim_ctrl.sv -----
// ttrim_ctrl: controller state machine of the text trim stream block
// sequences accept, pending flush and terminator; depends on ttrim_pkg
`timescale 1ns / 1ps

module ttrim_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  ttrim_pkg::ttrim_stat_t stat,
    output ttrim_pkg::ttrim_cmd_t  cmd
);

    ttrim_pkg::state_t state_reg;
    ttrim_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ttrim_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = ttrim_pkg::SRC_INPUT;
        unique case (state_reg)
            ttrim_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (s_tvalid)
                begin
                    if (stat.is_nul)
                    begin
                        // terminator goes out now or waits in its own state
                        if (stat.out_free)
                        begin
                            cmd.load_out   = 1'b1;
                            cmd.src        = ttrim_pkg::SRC_TERM;
                            cmd.term_clear = 1'b1;
                        end
                        else
                        begin
                            state_next = ttrim_pkg::ST_TERM;
                        end
                    end
                    else if (stat.is_trim)
                    begin
                        // leading trim bytes drop, inner ones are held
                        if (stat.in_body)
                        begin
                            if (stat.cnt_full)
                                cmd.set_ovf = 1'b1;
                            else
                                cmd.push = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.set_body = 1'b1;
                        if (stat.cnt_zero && stat.out_free)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.src      = ttrim_pkg::SRC_INPUT;
                        end
                        else
                        begin
                            cmd.capture = 1'b1;
                            if (stat.cnt_zero)
                            begin
                                state_next = ttrim_pkg::ST_LAST;
                            end
                            else
                            begin
                                cmd.ptr_clear = 1'b1;
                                state_next    = ttrim_pkg::ST_FLUSH;
                            end
                        end
                    end
                end
            end
            ttrim_pkg::ST_FLUSH:
            begin
                // one held byte per cycle from the pending buffer while the output is free
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.src      = ttrim_pkg::SRC_PENDING;
                    if (stat.flush_last)
                    begin
                        cmd.clear_count = 1'b1;
                        state_next      = ttrim_pkg::ST_LAST;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                    end
                end
            end
            ttrim_pkg::ST_LAST:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.src      = ttrim_pkg::SRC_HELD;
                    state_next   = ttrim_pkg::ST_IDLE;
                end
            end
            ttrim_pkg::ST_TERM:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.src        = ttrim_pkg::SRC_TERM;
                    cmd.term_clear = 1'b1;
                    state_next     = ttrim_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttrim_pkg::ST_IDLE;
            end
        endcase
    end

    // a flush is only ever entered with bytes in the buffer
    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttrim_pkg::ST_FLUSH) |-> !stat.cnt_zero)
        else $error("flush with empty pending buffer");

endmodule

// ----- design/text_trim_stream.sv -----
// text_trim_stream: top level of the streaming string trim block
// joins ttrim_ctrl and ttrim_dp; depends on ttrim_pkg
`timescale 1ns / 1ps

// Trims a NUL-terminated byte string arriving one byte per item. Leading
// trim-set bytes are dropped, inner trim-set bytes are held in a pending
// buffer of PENDING_DEPTH entries and sent ahead of the next kept byte,
// trailing ones are discarded at the NUL, which yields one terminator item
// (byte 0, tlast high, tuser = pending overflow seen during the string).
// tlast marks the last result item caused by an input item. Trim-set bytes
// and kept bytes with nothing held are taken in the idle state, so plain
// text runs at one item per cycle while the output is free. A kept byte
// after held bytes is captured and input waits while the held bytes leave
// the single read port of the pending buffer memory at one per cycle, then
// the kept byte. A stalled output holds the block once its output register
// is full. The pending buffer needs no clearing after reset. Configuration
// must be written only while no item is in flight; nothing here enforces it.

module text_trim_stream #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wen,
    input  logic [ttrim_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ttrim_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] byte_in
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] byte_out
    output logic                              m_tlast,   // run_end
    output logic                              m_tuser    // [0] overflowed
);

    ttrim_pkg::ttrim_cmd_t  cmd;
    ttrim_pkg::ttrim_stat_t stat;

    // controller
    ttrim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    ttrim_dp #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    assign s_tready = cmd.in_ready;

endmodule
